@@ sv/pole_pkg.sv @@
// ----------------------------------------------------------------------------
// pole_pkg
// Shared types and codes for the positional ordered list engine.
// ----------------------------------------------------------------------------
package pole_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int STAT_W = 3;
	localparam int POS_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_END   = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_DELETE    = 3'd3,
		MODE_UPDATE    = 3'd4,
		MODE_SEARCH    = 3'd5
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     sample;  // capture a new compare result this cycle
		logic     live;    // cell holds a valid entry
	} cell_ctl_t;

endpackage

@@ sv/pole_cell.sv @@
// ----------------------------------------------------------------------------
// pole_cell
// One list slot: holds an entry, takes it from a neighbor on shifts, and
// registers an equality compare against the search key.
// ----------------------------------------------------------------------------
module pole_cell
	import pole_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic signed [DATA_W-1:0] load_data,
	input  logic signed [DATA_W-1:0] key,
	output logic signed [DATA_W-1:0] data,
	output logic                     match
);

	logic signed [DATA_W-1:0] data_q;
	logic                     match_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			CELL_LOAD:       data_q <= load_data;
			default:         data_q <= data_q;
		endcase
		if (ctl.sample) begin
			match_q <= ctl.live && (data_q == key);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

@@ sv/positional_ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_engine
// Ordered list of signed 32-bit values with positional insert/delete,
// update and search, built as a row of shifting compare cells.
// ----------------------------------------------------------------------------
// Each transaction passes through accept, during which every cell
// compares its entry with the key; isolate the lowest matching cell; apply,
// during which the row shifts or loads in one step and the result register is
// written. The input is accepted again in the cycle after apply, so a new
// transaction is not taken before the last is applied; apply waits while the
// result register is still held by the consumer. Entries are packed from the
// first cell; position p lives in cell p-1. The entry store needs no clearing
// after reset.
module positional_ordered_list_engine
	import pole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] new_value,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [POS_W-1:0]         found_position,
	output logic [POS_W-1:0]         entry_total
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PICK,
		S_APPLY
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [MODE_W-1:0]        mode_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] nval_q;
	logic [POS_W-1:0]         pos_q;
	logic [CAPACITY-1:0]      first_q;
	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [POS_W-1:0]         found_q;
	logic [POS_W-1:0]         total_q;

	logic                     accept;
	logic                     apply_go;
	logic [CAPACITY-1:0]      match_vec;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	cell_ctl_t                cell_ctl [CAPACITY];
	logic signed [DATA_W-1:0] load_data;

	// apply-stage decode
	status_t       st_v;
	logic [POS_W-1:0] found_v;
	logic          do_ins;
	logic          do_del;
	logic          do_upd;
	logic [CW-1:0] slot_v;
	logic [IW-1:0] idx_v;
	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;
	logic          full;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign apply_go = (state_q == S_APPLY) && (!out_valid_q || out_ready);

	always_comb begin
		idx_v = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_q[i]) begin
				idx_v = idx_v | IW'(i);
			end
		end
	end

	always_comb begin
		pos_x   = PW'(pos_q);
		cnt_x   = PW'(count_q);
		full    = (count_q >= CW'(CAPACITY));
		st_v    = ST_OK;
		found_v = '0;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_upd  = 1'b0;
		slot_v  = '0;
		case (mode_t'(mode_q))
			MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
				if (full) begin
					st_v = ST_FULL;
				end else if (mode_q == MODE_INS_FRONT) begin
					do_ins = 1'b1;
				end else if (mode_q == MODE_INS_END) begin
					do_ins = 1'b1;
					slot_v = count_q;
				end else if (pos_x == PW'(1) || (pos_x > PW'(1) && pos_x <= cnt_x)) begin
					do_ins = 1'b1;
					slot_v = CW'(pos_x - PW'(1));
				end else begin
					st_v = ST_RANGE;
				end
			end
			MODE_DELETE: begin
				if (count_q == '0) begin
					st_v = ST_EMPTY;
				end else if (pos_x >= PW'(1) && pos_x <= cnt_x) begin
					do_del = 1'b1;
					slot_v = CW'(pos_x - PW'(1));
				end else begin
					st_v = ST_RANGE;
				end
			end
			MODE_UPDATE, MODE_SEARCH: begin
				if (count_q == '0) begin
					st_v = ST_EMPTY;
				end else if (first_q == '0) begin
					st_v = ST_NOTFOUND;
				end else begin
					found_v = POS_W'(32'(idx_v) + 32'd1);
					do_upd  = (mode_q == MODE_UPDATE);
				end
			end
			default: begin
				st_v = ST_OK;
			end
		endcase
	end

	assign load_data = do_upd ? nval_q : val_q;

	// per-cell control: shift right of the slot on insert, left on delete, load the first match on update
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_ctl[i].op     = CELL_HOLD;
			cell_ctl[i].sample = accept;
			cell_ctl[i].live   = (CW'(i) < count_q);
			if (apply_go) begin
				if (do_ins) begin
					if (CW'(i) == slot_v) begin
						cell_ctl[i].op = CELL_LOAD;
					end else if (CW'(i) > slot_v && CW'(i) <= count_q) begin
						cell_ctl[i].op = CELL_FROM_LEFT;
					end
				end else if (do_del) begin
					if (CW'(i) >= slot_v && CW'(i + 1) < count_q) begin
						cell_ctl[i].op = CELL_FROM_RIGHT;
					end
				end else if (do_upd && first_q[i]) begin
					cell_ctl[i].op = CELL_LOAD;
				end
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = val_q;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		pole_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.left_data  (left_w),
			.right_data (right_w),
			.load_data  (load_data),
			.key        (value),
			.data       (cell_data[g]),
			.match      (match_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) begin
						state_q <= S_IDLE;
						if (do_ins) begin
							count_q <= count_q + CW'(1);
						end else if (do_del) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			val_q  <= value;
			nval_q <= new_value;
			pos_q  <= position;
		end
		if (state_q == S_PICK) begin
			// keep only the lowest set match bit
			first_q <= match_vec & (~match_vec + CAPACITY'(1));
		end
		if (apply_go) begin
			status_q <= st_v;
			found_q  <= found_v;
			if (do_ins) begin
				total_q <= POS_W'(count_q + CW'(1));
			end else if (do_del) begin
				total_q <= POS_W'(count_q - CW'(1));
			end else begin
				total_q <= POS_W'(count_q);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign entry_total    = total_q;

endmodule
